>>> src/apt_pkg.sv
package apt_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int IDX_W   = 16;
  localparam int SEG_W   = 6;
  localparam int ANG_W   = 25;

  // arc kinds
  localparam logic [1:0] KIND_CCW    = 2'd0;
  localparam logic [1:0] KIND_CW     = 2'd1;
  localparam logic [1:0] KIND_CIRCLE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ARC_SEG   = 2'd0;
  localparam logic [1:0] REG_CIRC_SEG  = 2'd1;
  localparam logic [1:0] REG_EMIT_TAIL = 2'd2;

  // register reset values
  localparam logic [SEG_W-1:0] ARC_SEG_RST  = 6'd20;
  localparam logic [SEG_W-1:0] CIRC_SEG_RST = 6'd24;

  // angles: 2^25 is one turn
  localparam logic [ANG_W:0] TURN      = 26'd33554432;
  localparam logic [ANG_W:0] NEAR_TURN = 26'd33020368;

  // CORDIC start gain, Q30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  typedef struct packed {
    logic [1:0]                arc_kind;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]          radius;
    logic signed [COORD_W-1:0] head_x;
    logic signed [COORD_W-1:0] head_y;
    logic signed [COORD_W-1:0] tail_x;
    logic signed [COORD_W-1:0] tail_y;
    logic [IDX_W-1:0]          base_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      has_edge;
    logic [IDX_W-1:0]          edge_from;
    logic [IDX_W-1:0]          edge_to;
    logic                      last;
  } out_item_t;

  // one angle sweep: m samples from a0 toward a1
  typedef struct packed {
    logic [ANG_W:0]   a0;
    logic [ANG_W:0]   a1;
    logic [SEG_W-1:0] m;
    logic [IDX_W-1:0] base;
  } sweep_t;

  // work handed from the front to the back
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]          radius;
    logic signed [COORD_W-1:0] tail_x;
    logic signed [COORD_W-1:0] tail_y;
    sweep_t                    sw0;
    sweep_t                    sw1;
    logic                      s0_valid;
    logic                      s1_valid;
    logic                      tail_valid;
    logic                      circle;
  } plan_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // absolute angle distance of a sweep
  function automatic logic [ANG_W:0] ang_dist(input logic [ANG_W:0] a0,
                                              input logic [ANG_W:0] a1);
    return (a1 >= a0) ? a1 - a0 : a0 - a1;
  endfunction

  // clamp to the signed 32-bit coordinate range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [36:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 37'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/apt_fifo.sv
module apt_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("fifo count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == CW'($past(cnt_r) + 1'b1))
    else $error("fifo count did not grow on push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == CW'($past(cnt_r) - 1'b1))
    else $error("fifo count did not shrink on pop");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!do_push && !do_pop) |=> $stable(cnt_r) && $stable(rp_r))
    else $error("fifo moved without a beat");
`endif

endmodule

>>> src/apt_front.sv
module apt_front #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  apt_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_wdata,
  output logic              plan_push,
  output apt_pkg::plan_t    plan,
  input  logic              plan_full
);

  localparam int SW = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_RR, F_DD, F_SQRT, F_VEC, F_PLAN
  } state_t;

  state_t                     state_r;
  apt_pkg::in_item_t          item_r;
  logic                       pt_r;
  logic                       dxneg_r;
  logic signed [31:0]         dyc_r;
  logic [30:0]                dyabs_r;
  logic [61:0]                rr_r;
  logic [63:0]                v_r, res_r, bit_r;
  logic signed [35:0]         vx_r, vy_r;
  logic signed [33:0]         vz_r;
  logic [SW-1:0]              cnt_r;
  logic [24:0]                ang_b_r, ang_e_r;
  logic [5:0]                 arc_seg_r, circ_seg_r;
  logic                       emit_tail_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_seg_r   <= apt_pkg::ARC_SEG_RST;
      circ_seg_r  <= apt_pkg::CIRC_SEG_RST;
      emit_tail_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        apt_pkg::REG_ARC_SEG:   arc_seg_r   <= cfg_wdata;
        apt_pkg::REG_CIRC_SEG:  circ_seg_r  <= cfg_wdata;
        apt_pkg::REG_EMIT_TAIL: emit_tail_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // point offset from center, dy clamped to [-r, r]
  logic signed [31:0] px, py;
  logic signed [32:0] dx, dy, r33, dyc33, dyabs33;
  always_comb begin
    px      = pt_r ? item_r.tail_x : item_r.head_x;
    py      = pt_r ? item_r.tail_y : item_r.head_y;
    dx      = {px[31], px} - {item_r.center_x[31], item_r.center_x};
    dy      = {py[31], py} - {item_r.center_y[31], item_r.center_y};
    r33     = {2'b00, item_r.radius};
    if (dy > r33) dyc33 = r33;
    else if (dy < -r33) dyc33 = -r33;
    else dyc33 = dy;
    dyabs33 = (dyc33 < 0) ? -dyc33 : dyc33;
  end

  // integer square root step
  logic [63:0] trial, sq_v_nxt, sq_res_nxt;
  logic        sq_ge;
  always_comb begin
    trial      = res_r + bit_r;
    sq_ge      = (v_r >= trial);
    sq_v_nxt   = sq_ge ? v_r - trial : v_r;
    sq_res_nxt = sq_ge ? (res_r >> 1) + bit_r : res_r >> 1;
  end

  // vectoring CORDIC step and final angle
  logic signed [35:0] xs, ys, x_nxt, y_nxt;
  logic signed [33:0] at, z_nxt, zf, zr;
  always_comb begin
    xs = vx_r >>> cnt_r;
    ys = vy_r >>> cnt_r;
    at = $signed({4'b0000, apt_pkg::atan_lut(5'(cnt_r))});
    if (vy_r >= 0) begin
      x_nxt = vx_r + ys;
      y_nxt = vy_r - xs;
      z_nxt = vz_r + at;
    end else begin
      x_nxt = vx_r - ys;
      y_nxt = vy_r + xs;
      z_nxt = vz_r - at;
    end
    zf = dxneg_r ? 34'sh080000000 - z_nxt : z_nxt;
    zr = zf + 34'sd64;
  end

  // split the arc into sweeps
  logic [5:0]  n, h, mc;
  logic [25:0] b, e;
  always_comb begin
    n  = (arc_seg_r < 6'd2) ? 6'd2 : arc_seg_r;
    h  = n >> 1;
    mc = (circ_seg_r < 6'd3) ? 6'd3 : circ_seg_r;
    b  = {1'b0, ang_b_r};
    e  = {1'b0, ang_e_r};
    plan            = '0;
    plan.center_x   = item_r.center_x;
    plan.center_y   = item_r.center_y;
    plan.radius     = item_r.radius;
    plan.tail_x     = item_r.tail_x;
    plan.tail_y     = item_r.tail_y;
    plan.sw0.base   = item_r.base_index;
    plan.sw0.m      = n;
    plan.sw1.base   = item_r.base_index + 16'(h);
    plan.sw1.m      = h;
    if (item_r.arc_kind == apt_pkg::KIND_CIRCLE) begin
      plan.s0_valid = 1'b1;
      plan.circle   = 1'b1;
      plan.sw0.a0   = '0;
      plan.sw0.a1   = apt_pkg::TURN;
      plan.sw0.m    = mc;
    end else begin
      plan.tail_valid = emit_tail_r;
      if (item_r.arc_kind == apt_pkg::KIND_CW) begin
        if (e < b) begin
          plan.s0_valid = 1'b1;
          plan.sw0.a0 = b;
          plan.sw0.a1 = e;
        end else if (e > b) begin
          plan.s0_valid = 1'b1;
          if (b == '0) begin
            plan.sw0.a0 = apt_pkg::TURN;
            plan.sw0.a1 = e;
          end else if (e > apt_pkg::NEAR_TURN) begin
            plan.sw0.a0 = b;
            plan.sw0.a1 = '0;
          end else begin
            plan.s1_valid = 1'b1;
            plan.sw0.a0 = b;
            plan.sw0.a1 = '0;
            plan.sw0.m  = h;
            plan.sw1.a0 = apt_pkg::TURN;
            plan.sw1.a1 = e;
          end
        end
      end else begin
        if (e > b) begin
          plan.s0_valid = 1'b1;
          plan.sw0.a0 = b;
          plan.sw0.a1 = e;
        end else if (e < b) begin
          plan.s0_valid = 1'b1;
          if (e == '0) begin
            plan.sw0.a0 = b;
            plan.sw0.a1 = apt_pkg::TURN;
          end else if (b > apt_pkg::NEAR_TURN) begin
            plan.sw0.a0 = '0;
            plan.sw0.a1 = e;
          end else begin
            plan.s1_valid = 1'b1;
            plan.sw0.a0 = b;
            plan.sw0.a1 = apt_pkg::TURN;
            plan.sw0.m  = h;
            plan.sw1.a0 = '0;
            plan.sw1.a1 = e;
          end
        end
      end
    end
  end

  assign in_full   = (state_r != F_IDLE);
  assign plan_push = (state_r == F_PLAN) && !plan_full && (plan.s0_valid || plan.tail_valid);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            item_r <= in_item;
            pt_r   <= 1'b0;
            if (in_item.arc_kind == apt_pkg::KIND_CIRCLE) state_r <= F_PLAN;
            else if (in_item.arc_kind == apt_pkg::KIND_CCW ||
                     in_item.arc_kind == apt_pkg::KIND_CW) state_r <= F_PREP;
          end
        end
        F_PREP: begin
          dxneg_r <= (dx < 0);
          dyc_r   <= dyc33[31:0];
          dyabs_r <= dyabs33[30:0];
          state_r <= F_RR;
        end
        F_RR: begin
          rr_r    <= item_r.radius * item_r.radius;
          state_r <= F_DD;
        end
        F_DD: begin
          v_r     <= {2'b00, rr_r - dyabs_r * dyabs_r};
          res_r   <= '0;
          bit_r   <= 64'd1 << 62;
          state_r <= F_SQRT;
        end
        F_SQRT: begin
          v_r   <= sq_v_nxt;
          res_r <= sq_res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            vx_r    <= $signed({4'b0000, sq_res_nxt[31:0]});
            vy_r    <= 36'(dyc_r);
            vz_r    <= '0;
            cnt_r   <= '0;
            state_r <= F_VEC;
          end
        end
        F_VEC: begin
          vx_r  <= x_nxt;
          vy_r  <= y_nxt;
          vz_r  <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SW'(CORDIC_STEPS - 1)) begin
            if (!pt_r) begin
              ang_b_r <= zr[31:7];
              pt_r    <= 1'b1;
              state_r <= F_PREP;
            end else begin
              ang_e_r <= zr[31:7];
              state_r <= F_PLAN;
            end
          end
        end
        F_PLAN: begin
          if (!plan_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> src/apt_back.sv
module apt_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  apt_pkg::plan_t     plan,
  input  logic               plan_empty,
  output logic               plan_pop,
  output logic               out_push,
  output apt_pkg::out_item_t out_item,
  input  logic               out_full
);

  localparam int SW = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_ANG, B_ROT, B_MULX, B_MULY, B_FIN, B_EMIT, B_TAIL, B_DONE
  } state_t;

  state_t             state_r;
  logic               sw_r;
  logic [25:0]        num_r;
  logic [5:0]         rem_r;
  logic [4:0]         dcnt_r;
  logic [25:0]        q_r;
  logic [5:0]         rm_r;
  logic [5:0]         i_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               neg_r;
  logic [SW-1:0]      cnt_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] vx_r, vy_r;

  apt_pkg::sweep_t cur;
  logic            dir_neg;
  assign cur     = sw_r ? plan.sw1 : plan.sw0;
  assign dir_neg = (cur.a1 < cur.a0);

  // restoring divide step: distance / m
  logic [6:0] rem2;
  logic       d_ge;
  logic [5:0] rem_nxt;
  always_comb begin
    rem2    = {rem_r, num_r[25]};
    d_ge    = (rem2 >= {1'b0, cur.m});
    rem_nxt = d_ge ? 6'(rem2 - {1'b0, cur.m}) : rem2[5:0];
  end

  // sample angle into CORDIC start
  logic [24:0] alow;
  logic [31:0] t;
  logic        t_neg;
  always_comb begin
    alow  = dir_neg ? cur.a0[24:0] - q_r[24:0] : cur.a0[24:0] + q_r[24:0];
    t     = {alow, 7'b0};
    t_neg = t[31] ^ t[30];
  end

  // rotation step
  logic signed [33:0] xs, ys, at, x_nxt, y_nxt, z_nxt;
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = $signed({4'b0000, apt_pkg::atan_lut(5'(cnt_r))});
    if (z_r >= 0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  // scale by radius, round from Q30, add center
  logic signed [31:0] rs;
  logic signed [65:0] prod_rnd;
  logic signed [35:0] scl;
  logic signed [31:0] cpos;
  logic signed [31:0] pos_sat;
  always_comb begin
    rs       = $signed({1'b0, plan.radius});
    prod_rnd = prod_r + 66'sd536870912;
    scl      = prod_rnd[65:30];
    cpos     = (state_r == B_MULY) ? plan.center_x : plan.center_y;
    pos_sat  = apt_pkg::sat32(37'(cpos) + 37'(scl));
  end

  // next sample's quotient: q += d/m with remainder carry
  logic [6:0]  rm_sum;
  logic        wrap;
  logic        last_smp, final_sw;
  always_comb begin
    rm_sum   = {1'b0, rm_r} + {1'b0, rem_r};
    wrap     = (rm_sum >= {1'b0, cur.m});
    last_smp = (i_r == cur.m - 1'b1);
    final_sw = sw_r || !plan.s1_valid;
  end

  // result beat
  always_comb begin
    out_item = '0;
    if (state_r == B_TAIL) begin
      out_item.vertex_x = plan.tail_x;
      out_item.vertex_y = plan.tail_y;
      out_item.last     = 1'b1;
    end else begin
      out_item.vertex_x  = vx_r;
      out_item.vertex_y  = vy_r;
      out_item.has_edge  = 1'b1;
      out_item.edge_from = cur.base + 16'(i_r);
      out_item.edge_to   = (plan.circle && last_smp) ? cur.base
                                                     : cur.base + 16'(i_r) + 16'd1;
      out_item.last      = last_smp && final_sw && !plan.tail_valid;
    end
  end

  assign out_push = (state_r == B_EMIT || state_r == B_TAIL) && !out_full;
  assign plan_pop = (state_r == B_DONE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!plan_empty) begin
            sw_r   <= 1'b0;
            num_r  <= apt_pkg::ang_dist(plan.sw0.a0, plan.sw0.a1);
            rem_r  <= '0;
            dcnt_r <= '0;
            q_r    <= '0;
            rm_r   <= '0;
            i_r    <= '0;
            state_r <= plan.s0_valid ? B_DIV : B_TAIL;
          end
        end
        B_DIV: begin
          rem_r  <= rem_nxt;
          num_r  <= {num_r[24:0], d_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd25) state_r <= B_ANG;
        end
        B_ANG: begin
          x_r     <= apt_pkg::CORDIC_K;
          y_r     <= '0;
          z_r     <= 34'($signed({t[31] ^ t_neg, t[30:0]}));
          neg_r   <= t_neg;
          cnt_r   <= '0;
          state_r <= B_ROT;
        end
        B_ROT: begin
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SW'(CORDIC_STEPS - 1)) begin
            x_r     <= neg_r ? -x_nxt : x_nxt;
            y_r     <= neg_r ? -y_nxt : y_nxt;
            state_r <= B_MULX;
          end else begin
            x_r <= x_nxt;
            y_r <= y_nxt;
          end
        end
        B_MULX: begin
          prod_r  <= rs * 66'(x_r);
          state_r <= B_MULY;
        end
        B_MULY: begin
          vx_r    <= pos_sat;
          prod_r  <= rs * 66'(y_r);
          state_r <= B_FIN;
        end
        B_FIN: begin
          vy_r    <= pos_sat;
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (!out_full) begin
            if (!last_smp) begin
              // advance to the next sample of this sweep
              i_r     <= i_r + 1'b1;
              q_r     <= q_r + num_r + 26'(wrap);
              rm_r    <= wrap ? 6'(rm_sum - {1'b0, cur.m}) : rm_sum[5:0];
              state_r <= B_ANG;
            end else if (!sw_r && plan.s1_valid) begin
              sw_r   <= 1'b1;
              num_r  <= apt_pkg::ang_dist(plan.sw1.a0, plan.sw1.a1);
              rem_r  <= '0;
              dcnt_r <= '0;
              q_r    <= '0;
              rm_r   <= '0;
              i_r    <= '0;
              state_r <= B_DIV;
            end else if (plan.tail_valid) begin
              state_r <= B_TAIL;
            end else begin
              state_r <= B_DONE;
            end
          end
        end
        B_TAIL: begin
          if (!out_full) state_r <= B_DONE;
        end
        B_DONE: state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> src/arc_polyline_tessellator_core.sv
// Arc tessellator: takes one circular arc (CCW or CW, from head point to tail
// point about a center) or a full circle, and emits polyline vertices in Q19.12
// with edge indices counted from base_index; a circle's last edge closes back to
// base_index and an arc may end with its exact tail point, which carries no edge.
// The front finds the head and tail angles (one 31x31 multiply pair, a 32-step
// square root and a CORDIC_STEPS vectoring pass per point) and hands a sweep
// plan through a two-entry queue to the back, which runs a restoring divide per
// sweep and a rotation CORDIC and radius multiply per vertex. Results wait in a
// two-entry output queue.
module arc_polyline_tessellator_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  apt_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output apt_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_wdata
);

  apt_pkg::plan_t     plan_in, plan_out;
  logic               plan_push, plan_full, plan_pop, plan_empty;
  apt_pkg::out_item_t res_in;
  logic               res_push, res_full;

  apt_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .plan_push (plan_push),
    .plan      (plan_in),
    .plan_full (plan_full)
  );

  // plan queue between front and back
  apt_fifo #(.T(apt_pkg::plan_t), .DEPTH(2)) u_plan_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (plan_push),
    .din   (plan_in),
    .full  (plan_full),
    .pop   (plan_pop),
    .dout  (plan_out),
    .empty (plan_empty)
  );

  apt_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan_out),
    .plan_empty (plan_empty),
    .plan_pop   (plan_pop),
    .out_push   (res_push),
    .out_item   (res_in),
    .out_full   (res_full)
  );

  // result queue
  apt_fifo #(.T(apt_pkg::out_item_t), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

>>> verif/arc_polyline_tessellator_core_test.sv
module arc_polyline_tessellator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS     = 24;
  localparam int MAX_VERTS = 64;
  localparam int SETTLE    = 400;
  localparam longint ONE_TURN = 64'sd33554432;
  localparam longint WRAP_LIMIT = 64'sd33020368;
  localparam longint START_GAIN = 64'sd652032874;
  // arc kind with no meaning
  localparam logic [1:0] KIND_NONE = 2'd3;

  // atan(2^-i), 2^-32 turn units
  localparam longint ATAN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  apt_pkg::in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  apt_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = apt_pkg::REG_ARC_SEG;
  logic [5:0] cfg_wdata = '0;

  // shadow of the segment/tail registers
  logic [5:0] arc_seg_now = apt_pkg::ARC_SEG_RST;
  logic [5:0] circ_seg_now = apt_pkg::CIRC_SEG_RST;
  logic emit_tail_now = 1'b1;

  apt_pkg::out_item_t pending_verts[$];
  int fail_count = 0;
  bit quiet = 1'b0;

  arc_polyline_tessellator_core #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------- vertex predictor ----------------

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // angle of a point about the center, 25-bit turns
  function automatic longint point_turns(longint cx, longint cy, longint px, longint py,
                                         longint r);
    longint dx, dy, x, y, z, xs, ys;
    dx = px - cx;
    dy = py - cy;
    if (dy > r) dy = r;
    if (dy < -r) dy = -r;
    x = longint'(int_sqrt(longint'(r * r - dy * dy)));
    y = dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> (i & 31);
      ys = y >>> (i & 31);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i & 31];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i & 31];
      end
    end
    if (dx >= 0) begin
      if (z < 0) z += 64'sd4294967296;
    end else begin
      z = 64'sd2147483648 - z;
    end
    return ((z + 64) >>> 7) & 64'h1FFFFFF;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // m vertices from a0 toward a1, edges counted from base
  function automatic void add_sweep(ref apt_pkg::out_item_t verts[$], input longint cx,
                                    input longint cy, input longint r, input longint a0,
                                    input longint a1, input int m, input logic [15:0] base);
    longint diff, span, mag, a, x, y, z, xs, ys;
    logic [31:0] t;
    bit flip;
    apt_pkg::out_item_t v;
    diff = a1 - a0;
    span = diff < 0 ? -diff : diff;
    for (int i = 0; i < m && verts.size() < MAX_VERTS; i++) begin
      mag = (span * i) / m;
      a = diff < 0 ? a0 - mag : a0 + mag;
      t = {a[24:0], 7'b0};
      flip = 1'b0;
      if (t >= 32'h40000000 && t < 32'hC0000000) begin
        flip = 1'b1;
        t = t - 32'h80000000;
      end
      z = longint'($signed(t));
      x = START_GAIN;
      y = 0;
      for (int s = 0; s < STEPS; s++) begin
        xs = x >>> (s & 31);
        ys = y >>> (s & 31);
        if (z >= 0) begin
          x -= ys; y += xs; z -= ATAN_STEP[s & 31];
        end else begin
          x += ys; y -= xs; z += ATAN_STEP[s & 31];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      v.vertex_x = clamp32(cx + ((r * x + (64'sd1 << 29)) >>> 30));
      v.vertex_y = clamp32(cy + ((r * y + (64'sd1 << 29)) >>> 30));
      v.has_edge = 1'b1;
      v.edge_from = base + 16'(i);
      v.edge_to = base + 16'(i) + 16'd1;
      v.last = 1'b0;
      verts = {verts, v};
    end
  endfunction

  function automatic void predict_verts(apt_pkg::in_item_t it);
    apt_pkg::out_item_t verts[$];
    apt_pkg::out_item_t tv;
    longint cx, cy, r, hx, hy, tx, ty, b, e;
    int n, h, m;
    logic [15:0] base, base2;
    cx = longint'($signed(it.center_x));
    cy = longint'($signed(it.center_y));
    r = longint'(it.radius);
    base = it.base_index;
    if (it.arc_kind == apt_pkg::KIND_CIRCLE) begin
      m = circ_seg_now < 3 ? 3 : int'(circ_seg_now);
      add_sweep(verts, cx, cy, r, 0, ONE_TURN, m, base);
      if (verts.size() > 0) verts[verts.size() - 1].edge_to = base;
    end else if (it.arc_kind == apt_pkg::KIND_CCW || it.arc_kind == apt_pkg::KIND_CW) begin
      n = arc_seg_now < 2 ? 2 : int'(arc_seg_now);
      h = n / 2;
      base2 = base + 16'(h);
      hx = longint'($signed(it.head_x));
      hy = longint'($signed(it.head_y));
      tx = longint'($signed(it.tail_x));
      ty = longint'($signed(it.tail_y));
      b = point_turns(cx, cy, hx, hy, r);
      e = point_turns(cx, cy, tx, ty, r);
      if (it.arc_kind == apt_pkg::KIND_CW) begin
        if (e < b) add_sweep(verts, cx, cy, r, b, e, n, base);
        else if (e > b) begin
          if (b == 0) add_sweep(verts, cx, cy, r, ONE_TURN, e, n, base);
          else if (e > WRAP_LIMIT) add_sweep(verts, cx, cy, r, b, 0, n, base);
          else begin
            add_sweep(verts, cx, cy, r, b, 0, h, base);
            add_sweep(verts, cx, cy, r, ONE_TURN, e, h, base2);
          end
        end
      end else begin
        if (e > b) add_sweep(verts, cx, cy, r, b, e, n, base);
        else if (e < b) begin
          if (e == 0) add_sweep(verts, cx, cy, r, b, ONE_TURN, n, base);
          else if (b > WRAP_LIMIT) add_sweep(verts, cx, cy, r, 0, e, n, base);
          else begin
            add_sweep(verts, cx, cy, r, b, ONE_TURN, h, base);
            add_sweep(verts, cx, cy, r, 0, e, h, base2);
          end
        end
      end
      if (emit_tail_now && verts.size() < MAX_VERTS) begin
        tv = '0;
        tv.vertex_x = it.tail_x;
        tv.vertex_y = it.tail_y;
        verts = {verts, tv};
      end
    end
    if (verts.size() > 0) verts[verts.size() - 1].last = 1'b1;
    pending_verts = {pending_verts, verts};
  endfunction

  // ---------------- driving ----------------

  task automatic send_arc(apt_pkg::in_item_t it);
    predict_verts(it);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 9) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
  endtask

  // drop push, wait out all vertices, then let the front go idle
  task automatic settle();
    in_push <= 1'b0;
    while (pending_verts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      apt_pkg::REG_ARC_SEG:   arc_seg_now = val;
      apt_pkg::REG_CIRC_SEG:  circ_seg_now = val;
      apt_pkg::REG_EMIT_TAIL: emit_tail_now = val[0];
      default: ;
    endcase
  endtask

  // pop side: random stalls
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= quiet || ($urandom_range(0, 99) >= 9);
  end

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // beat check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    apt_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_verts.size() == 0) begin
        report($sformatf("unexpected beat x=%0d y=%0d", out_item.vertex_x,
                         out_item.vertex_y));
      end else begin
        want = pending_verts.pop_front();
        if (out_item.vertex_x !== want.vertex_x)
          report($sformatf("vertex_x %0d want %0d", out_item.vertex_x, want.vertex_x));
        if (out_item.vertex_y !== want.vertex_y)
          report($sformatf("vertex_y %0d want %0d", out_item.vertex_y, want.vertex_y));
        if (out_item.has_edge !== want.has_edge)
          report($sformatf("has_edge %0b want %0b", out_item.has_edge, want.has_edge));
        if (out_item.edge_from !== want.edge_from)
          report($sformatf("edge_from %0d want %0d", out_item.edge_from, want.edge_from));
        if (out_item.edge_to !== want.edge_to)
          report($sformatf("edge_to %0d want %0d", out_item.edge_to, want.edge_to));
        if (out_item.last !== want.last)
          report($sformatf("last %0b want %0b", out_item.last, want.last));
      end
    end
  end

  // ---------------- item builders ----------------

  // point at deg degrees on the circle, 32-bit wrapped
  function automatic logic [63:0] on_circle(longint cx, longint cy, longint r, real deg);
    longint px, py;
    px = cx + longint'($rtoi(real'(r) * $cos(deg * 3.14159265358979 / 180.0)));
    py = cy + longint'($rtoi(real'(r) * $sin(deg * 3.14159265358979 / 180.0)));
    return {px[31:0], py[31:0]};
  endfunction

  function automatic apt_pkg::in_item_t make_arc(logic [1:0] kind, longint cx, longint cy,
                                                 longint r, real head_deg, real tail_deg,
                                                 logic [15:0] base);
    apt_pkg::in_item_t it;
    logic [63:0] p;
    it.arc_kind = kind;
    it.center_x = cx[31:0];
    it.center_y = cy[31:0];
    it.radius = r[30:0];
    p = on_circle(cx, cy, r, head_deg);
    {it.head_x, it.head_y} = p;
    p = on_circle(cx, cy, r, tail_deg);
    {it.tail_x, it.tail_y} = p;
    it.base_index = base;
    return it;
  endfunction

  function automatic apt_pkg::in_item_t random_arc();
    apt_pkg::in_item_t it;
    int pick;
    longint cx, cy, r;
    logic [1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = apt_pkg::KIND_CCW;
    else if (pick < 80) kind = apt_pkg::KIND_CW;
    else if (pick < 95) kind = apt_pkg::KIND_CIRCLE;
    else kind = KIND_NONE;
    if ($urandom_range(0, 9) == 0) begin
      // raw bits, anything goes
      it = {kind, $urandom(), $urandom(), 31'($urandom()), $urandom(), $urandom(),
            $urandom(), $urandom(), 16'($urandom_range(0, 65471))};
    end else begin
      cx = longint'($urandom_range(0, 32'h1FFFFFFF)) - 64'sd268435456;
      cy = longint'($urandom_range(0, 32'h1FFFFFFF)) - 64'sd268435456;
      r = longint'($urandom_range(0, 32'hFFFFFF));
      it = make_arc(kind, cx, cy, r, real'($urandom_range(0, 3599)) / 10.0,
                    real'($urandom_range(0, 3599)) / 10.0, 16'($urandom_range(0, 65471)));
      if ($urandom_range(0, 19) == 0) begin
        it.tail_x = it.head_x;
        it.tail_y = it.head_y;
      end
      // off-circle jitter
      if ($urandom_range(0, 3) == 0) begin
        it.head_y = it.head_y + 32'($urandom_range(0, 8191)) - 32'sd4096;
        it.tail_x = it.tail_x + 32'($urandom_range(0, 8191)) - 32'sd4096;
      end
    end
    return it;
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_settings();
    send_arc(make_arc(apt_pkg::KIND_CIRCLE, 0, 0, 64'sd409600, 0.0, 0.0, 16'd0));
    send_arc(make_arc(apt_pkg::KIND_CCW, 64'sd40960, -64'sd81920, 64'sd204800, 10.0, 100.0,
                      16'd7));
    send_arc(make_arc(apt_pkg::KIND_CW, 64'sd40960, -64'sd81920, 64'sd204800, 100.0, 10.0,
                      16'd300));
    // unknown kind emits nothing
    send_arc(make_arc(KIND_NONE, 0, 0, 64'sd4096, 10.0, 50.0, 16'd1));
    // head on tail: only the tail point
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, 64'sd8192, 45.0, 45.0, 16'd2));
    settle();
  endtask

  task automatic test_wrap_cases();
    apt_pkg::in_item_t it;
    longint r;
    r = 64'sd1048576;
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, r, 300.0, 60.0, 16'd10));    // split at zero
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, r, 120.0, 0.0, 16'd20));     // tail at zero
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, r, 359.7, 60.0, 16'd30));    // head near a turn
    send_arc(make_arc(apt_pkg::KIND_CW, 0, 0, r, 0.0, 200.0, 16'd40));      // head at zero
    send_arc(make_arc(apt_pkg::KIND_CW, 0, 0, r, 60.0, 359.7, 16'd50));     // tail near a turn
    send_arc(make_arc(apt_pkg::KIND_CW, 0, 0, r, 60.0, 300.0, 16'd60));     // split at zero
    // zero radius, one point left of center
    it = make_arc(apt_pkg::KIND_CCW, 64'sd1000, 64'sd2000, 0, 0.0, 0.0, 16'd70);
    it.head_x = 32'sd5000;
    it.tail_x = -32'sd5000;
    send_arc(it);
    // dy beyond the radius clamps
    it = make_arc(apt_pkg::KIND_CW, 0, 0, 64'sd4096, 0.0, 0.0, 16'd80);
    it.head_y = 32'sh7FFFFFFF;
    it.tail_y = 32'sh80000000;
    it.tail_x = -32'sd10;
    send_arc(it);
    // saturation near both rails, high base index that stays below the wrap
    send_arc(make_arc(apt_pkg::KIND_CIRCLE, 64'sd2147000000, -64'sd2147000000,
                      64'sd2147483647, 0.0, 0.0, 16'd65471));
    it = '0;
    it.arc_kind = apt_pkg::KIND_CCW;
    it.center_x = 32'sh80000000;
    it.center_y = 32'sh7FFFFFFF;
    it.radius = 31'h7FFFFFFF;
    it.head_x = 32'sh7FFFFFFF;
    it.head_y = 32'sh80000000;
    it.tail_x = 32'sh80000000;
    it.tail_y = 32'sh7FFFFFFF;
    it.base_index = 16'd65471;
    send_arc(it);
    settle();
  endtask

  task automatic test_register_extremes();
    reg_write(apt_pkg::REG_ARC_SEG, 6'd0);
    reg_write(apt_pkg::REG_CIRC_SEG, 6'd0);
    reg_write(apt_pkg::REG_EMIT_TAIL, 6'd0);
    send_arc(make_arc(apt_pkg::KIND_CIRCLE, 0, 0, 64'sd40960, 0.0, 0.0, 16'd5));
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, 64'sd40960, 30.0, 150.0, 16'd5));
    send_arc(make_arc(apt_pkg::KIND_CW, 0, 0, 64'sd40960, 30.0, 330.0, 16'd5));
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, 64'sd40960, 30.0, 30.0, 16'd5));
    settle();
    reg_write(apt_pkg::REG_ARC_SEG, 6'd63);
    reg_write(apt_pkg::REG_CIRC_SEG, 6'd63);
    reg_write(apt_pkg::REG_EMIT_TAIL, 6'd1);
    send_arc(make_arc(apt_pkg::KIND_CIRCLE, 64'sd4096, 0, 64'sd81920, 0.0, 0.0, 16'd65400));
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, 64'sd81920, 20.0, 200.0, 16'd0));
    send_arc(make_arc(apt_pkg::KIND_CCW, 0, 0, 64'sd81920, 200.0, 20.0, 16'd0));  // odd split
    settle();
    reg_write(apt_pkg::REG_ARC_SEG, 6'd1);
    reg_write(apt_pkg::REG_CIRC_SEG, 6'd2);
    send_arc(make_arc(apt_pkg::KIND_CIRCLE, 0, 0, 64'sd81920, 0.0, 0.0, 16'd9));
    send_arc(make_arc(apt_pkg::KIND_CW, 0, 0, 64'sd81920, 10.0, 350.0, 16'd9));
    settle();
  endtask

  task automatic test_random_arcs();
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      if (ph == 4) begin
        reg_write(apt_pkg::REG_ARC_SEG, 6'd62);
        reg_write(apt_pkg::REG_CIRC_SEG, 6'd3);
      end else begin
        reg_write(apt_pkg::REG_ARC_SEG, 6'($urandom_range(0, 12)));
        reg_write(apt_pkg::REG_CIRC_SEG, 6'($urandom_range(0, 12)));
      end
      reg_write(apt_pkg::REG_EMIT_TAIL, 6'($urandom_range(0, 1)));
      for (int i = 0; i < 38; i++) send_arc(random_arc());
      settle();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_wrap_cases();
    test_register_extremes();
    test_random_arcs();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
